// ----- rtl/rwn_pkg.sv -----
// ----------------------------------------------------------------------------
// rwn_pkg: random walk noise generator package
// Shared constants, payload types and the sequencer-to-divider request/status
// records used by the core and its iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rwn_pkg;

   // channel store and output format
   localparam int CHANNELS    = 64;
   localparam int CH_W        = $clog2(CHANNELS);
   localparam int CHAN_BITS   = 6;
   localparam int SAMPLE_BITS = 24;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_METHOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JITTER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 3'd5;

   // noise methods
   localparam logic [1:0] METHOD_WHITE   = 2'd0;
   localparam logic [1:0] METHOD_LOWPASS = 2'd1;
   localparam logic [1:0] METHOD_WALK    = 2'd2;
   localparam logic [1:0] METHOD_SIGN    = 2'd3;

   // register reset values
   localparam logic [1:0]  RST_METHOD = 2'd3;
   localparam logic [25:0] RST_FREQ   = 26'd131072;
   localparam logic [16:0] RST_JITTER = 17'd16384;
   localparam logic [16:0] RST_LEVEL  = 17'd65536;
   localparam logic [17:0] RST_RATE   = 18'd48000;
   localparam logic [31:0] RST_SEED   = 32'd1;

   // generator constants
   localparam logic [31:0] LCG_MUL      = 32'd1664525;
   localparam logic [31:0] LCG_ADD      = 32'd1013904223;
   localparam logic [31:0] SEED_DEFAULT = 32'h1234_5678;
   localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
   localparam logic [34:0] NINE_Q30     = 35'd9663676416;
   localparam logic [37:0] SEVENTEEN_Q30 = 38'd18253611008;
   localparam logic [34:0] TWO_PI_Q32   = 35'd26986075409;
   localparam logic [19:0] W_LIMIT_Q32  = 20'd611929;
   localparam logic [29:0] LN2_Q30      = 30'd744261118;
   localparam logic [32:0] A1_ONE       = 33'h1_0000_0000;

   // exp taylor coefficients, Q1.30
   localparam logic [30:0] EXP_COEF [8] = '{
      31'd1073741824, 31'd1073741824, 31'd536870912, 31'd178956971,
      31'd44739243,   31'd8947849,    31'd1491308,   31'd213044
   };

   // shared unit widths
   localparam int MUL_W     = 34;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int DIV_NUM_W = 68;
   localparam int DIV_DEN_W = 38;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      logic                 reseed;
   } rwn_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CHAN_BITS-1:0]          channel_out;
   } rwn_rsp_type;

   typedef struct packed {
      logic [31:0]        lcg;
      logic signed [31:0] walk;
      logic signed [31:0] smooth;
   } rwn_entry_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } rwn_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } rwn_div_sts_type;

endpackage

`default_nettype wire

// ----- rtl/rwn_ram.sv -----
// ----------------------------------------------------------------------------
// rwn_ram: generic single-port-write, registered-read RAM
// One write port and one read port with read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rwn_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rwn_div.sv -----
// ----------------------------------------------------------------------------
// rwn_div: iterative restoring divider
// Unsigned divide, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
`default_nettype none

module rwn_div import rwn_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire rwn_div_req_type div_req,
   output rwn_div_sts_type      div_sts
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] nq_ff, nq_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 fits;

   // one restoring step
   assign rem_sh = {rem_ff[DIV_DEN_W-1:0], nq_ff[DIV_NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      nq_in   = nq_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         rem_in  = '0;
         nq_in   = div_req.num;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         nq_in  = {nq_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      den_ff <= den_in;
   end

   assign div_sts.done = done_ff;
   assign div_sts.quot = nq_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !div_req.start && cnt_ff == DIV_CNT_W'(1)) |=> done_ff)
      else $error("divider missed done");

endmodule

`default_nettype wire

// ----- rtl/rwn_mul.sv -----
// ----------------------------------------------------------------------------
// rwn_mul: shared signed multiplier
// Signed multiply with a registered product, one product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rwn_mul import rwn_pkg::*; (
   input  wire logic                     clock,
   input  wire logic signed [MUL_W-1:0]  op_a,
   input  wire logic signed [MUL_W-1:0]  op_b,
   output logic signed      [PROD_W-1:0] prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // product registered for the next sequencer step
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ----- rtl/random_walk_noise_generator_core.sv -----
// ----------------------------------------------------------------------------
// random_walk_noise_generator_core: multi-channel random walk noise source
// Per-channel LCG noise, clamped random walk, one-pole smoother and level.
// ----------------------------------------------------------------------------
// One item at a time. After reset or any register write, the first sample
// item first runs a coefficient pass (four or five 68-step divisions on the
// shared divider plus, for a nonzero cutoff, a 7-step exp polynomial on the
// shared multiplier); later items reuse those coefficients. Sample items are
// paced by the shared multiplier. Channel state lives in a 64-entry RAM with
// a valid bit per channel, so no clearing pass is needed after reset.
`default_nettype none

module random_walk_noise_generator_core import rwn_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire rwn_req_type          req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rwn_rsp_type               rsp_data,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   typedef enum logic [28:0] {
      ST_IDLE     = 29'h0000_0001,
      ST_DISPATCH = 29'h0000_0002,
      ST_INC_GO   = 29'h0000_0004,
      ST_INC_WAIT = 29'h0000_0008,
      ST_JIT_GO   = 29'h0000_0010,
      ST_JIT_WAIT = 29'h0000_0020,
      ST_SHP_GO   = 29'h0000_0040,
      ST_SHP_WAIT = 29'h0000_0080,
      ST_MIX_GO   = 29'h0000_0100,
      ST_MIX_WAIT = 29'h0000_0200,
      ST_K_GO     = 29'h0000_0400,
      ST_K_WAIT   = 29'h0000_0800,
      ST_W_MUL    = 29'h0000_1000,
      ST_W_RES    = 29'h0000_2000,
      ST_EXP_MUL  = 29'h0000_4000,
      ST_EXP_RES  = 29'h0000_8000,
      ST_LCG_MUL  = 29'h0001_0000,
      ST_NOISE    = 29'h0002_0000,
      ST_STEP_MUL = 29'h0004_0000,
      ST_STEP_RES = 29'h0008_0000,
      ST_MX1      = 29'h0010_0000,
      ST_MX2      = 29'h0020_0000,
      ST_MX3      = 29'h0040_0000,
      ST_LP1      = 29'h0080_0000,
      ST_LP2      = 29'h0100_0000,
      ST_LP3      = 29'h0200_0000,
      ST_OUT_MUL  = 29'h0400_0000,
      ST_OUT_RES  = 29'h0800_0000,
      ST_DONE     = 29'h1000_0000
   } state_type;

   localparam int OUT_SHR = (SAMPLE_BITS <= 31) ? (31 - SAMPLE_BITS) : 0;
   localparam int OUT_SHL = (SAMPLE_BITS <= 31) ? 0 : 1;
   localparam logic signed [52:0] SMAX = 53'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [52:0] SMIN = -SMAX - 53'sd1;

   // sequencer and item registers
   state_type            state_ff, state_in;
   logic [CHAN_BITS-1:0] chan_ff, chan_in;
   logic                 reseed_ff, reseed_in;
   logic [31:0]          lcg_ff, lcg_in;
   logic signed [31:0]   walk_ff, walk_in;
   logic signed [31:0]   smooth_ff, smooth_in;
   logic signed [31:0]   noise_ff, noise_in;
   logic signed [31:0]   x_ff, x_in;
   logic signed [31:0]   y_ff, y_in;
   logic signed [PROD_W-1:0] t_ff, t_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;

   // coefficient registers
   logic                 coef_ok_ff, coef_ok_in;
   logic [30:0]          inc_ff, inc_in;
   logic [30:0]          jit_ff, jit_in;
   logic [30:0]          ss_ff, ss_in;
   logic [30:0]          wmix_ff, wmix_in;
   logic [19:0]          k_ff, k_in;
   logic [29:0]          yv_ff, yv_in;
   logic signed [33:0]   acc_ff, acc_in;
   logic [32:0]          a1_ff, a1_in;
   logic [2:0]           hcnt_ff, hcnt_in;

   // configuration registers
   logic [1:0]           method_ff, method_in;
   logic [25:0]          freq_ff, freq_in;
   logic [16:0]          jitter_ff, jitter_in;
   logic [16:0]          level_ff, level_in;
   logic [17:0]          rate_ff, rate_in;
   logic [31:0]          seed_ff, seed_in;

   logic [CHANNELS-1:0]  valid_ff, valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rwn_rsp_type          rsp_data_ff, rsp_data_in;

   // shared units
   rwn_div_req_type          div_req;
   rwn_div_sts_type          div_sts;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   // channel store
   logic                 ram_wr_en, ram_rd_en;
   logic [CH_W-1:0]      ram_addr, ram_rd_addr;
   rwn_entry_type        ram_wr_data, ram_rd_data, entry;

   // datapath helpers
   logic                 accept, chan_ok, rsp_load;
   logic [17:0]          rate1;
   logic [30:0]          avg;
   logic [34:0]          ten_avg, t_raw;
   logic [30:0]          t_mix;
   logic                 mix_on;
   logic [37:0]          shp_prod;
   logic [31:0]          lcg_new;
   logic signed [31:0]   noise_new;
   logic signed [32:0]   yv_s;
   logic signed [33:0]   acc_new;
   logic [34:0]          a1_raw;
   logic signed [33:0]   step, wv;
   logic signed [PROD_W-1:0] pair_sum;
   logic [32:0]          b0;
   logic signed [52:0]   v_sh;

   function automatic logic [30:0] sat30(input logic [DIV_NUM_W-1:0] q);
      sat30 = (q > DIV_NUM_W'(ONE_Q30)) ? ONE_Q30 : q[30:0];
   endfunction

   rwn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   rwn_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   rwn_ram #(
      .WIDTH ($bits(rwn_entry_type)),
      .DEPTH (CHANNELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // handshake
   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign ram_rd_en   = accept;
   assign ram_rd_addr = CH_W'(req_data.channel);
   assign ram_addr    = CH_W'(chan_ff);
   assign chan_ok     = {3'b000, chan_ff} < 9'(CHANNELS);
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   // never-written channels read as their reset contents
   always_comb begin
      entry = ram_rd_data;
      if (!valid_ff[ram_addr]) begin
         entry.lcg    = SEED_DEFAULT;
         entry.walk   = '0;
         entry.smooth = '0;
      end
   end

   // coefficient arithmetic
   assign rate1    = (rate_ff == 18'd0) ? 18'd1 : rate_ff;
   assign avg      = 31'((32'(inc_ff) + 32'(jit_ff)) >> 1);
   assign ten_avg  = (35'(avg) << 3) + (35'(avg) << 1);
   assign mix_on   = ten_avg >= NINE_Q30;
   assign t_raw    = ten_avg - NINE_Q30;
   assign t_mix    = (t_raw > 35'(ONE_Q30)) ? ONE_Q30 : t_raw[30:0];
   assign shp_prod = 38'(jit_ff) * 38'd199;
   assign yv_s     = $signed(33'(LN2_Q30)) - $signed({3'b000, prod_ff[47:18]});
   assign acc_new  = $signed(34'(EXP_COEF[hcnt_ff])) + $signed(prod_ff[63:30]);
   assign a1_raw   = 35'(acc_new) << 1;

   // sample arithmetic
   assign lcg_new   = prod_ff[31:0] + LCG_ADD;
   assign noise_new = $signed({1'b0, lcg_new[31:1]}) - $signed(32'(ONE_Q30));
   assign pair_sum  = t_ff + prod_ff;
   assign b0        = A1_ONE - a1_ff;
   assign v_sh      = ($signed(prod_ff[67:16]) >>> OUT_SHR) <<< OUT_SHL;

   always_comb begin
      if (method_ff == METHOD_SIGN) begin
         step = (noise_ff > 32'sd0) ? $signed(34'(ss_ff)) : -$signed(34'(ss_ff));
      end else begin
         step = $signed(prod_ff[63:30]);
      end
      wv = 34'(walk_ff) + step;
      if (wv > $signed(34'(ONE_Q30))) begin
         wv = $signed(34'(ONE_Q30));
      end else if (wv < -$signed(34'(ONE_Q30))) begin
         wv = -$signed(34'(ONE_Q30));
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_W_MUL: begin
            mul_a = $signed(34'(k_ff));
            mul_b = $signed(34'(freq_ff));
         end
         ST_EXP_MUL: begin
            mul_a = acc_ff;
            mul_b = $signed(34'(yv_ff));
         end
         ST_LCG_MUL: begin
            mul_a = $signed(34'(lcg_ff));
            mul_b = $signed(34'(LCG_MUL));
         end
         ST_STEP_MUL: begin
            mul_a = 34'(noise_ff);
            mul_b = $signed(34'(ss_ff));
         end
         ST_MX1: begin
            mul_a = 34'(walk_ff);
            mul_b = $signed(34'(ONE_Q30 - wmix_ff));
         end
         ST_MX2: begin
            mul_a = 34'(noise_ff);
            mul_b = $signed(34'(wmix_ff));
         end
         ST_LP1: begin
            mul_a = 34'(x_ff);
            mul_b = $signed(34'(b0));
         end
         ST_LP2: begin
            mul_a = $signed(34'(a1_ff));
            mul_b = 34'(smooth_ff);
         end
         ST_OUT_MUL: begin
            mul_a = 34'(y_ff);
            mul_b = $signed(34'(level_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      chan_in     = chan_ff;
      reseed_in   = reseed_ff;
      lcg_in      = lcg_ff;
      walk_in     = walk_ff;
      smooth_in   = smooth_ff;
      noise_in    = noise_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      t_in        = t_ff;
      sample_in   = sample_ff;
      coef_ok_in  = coef_ok_ff;
      inc_in      = inc_ff;
      jit_in      = jit_ff;
      ss_in       = ss_ff;
      wmix_in     = wmix_ff;
      k_in        = k_ff;
      yv_in       = yv_ff;
      acc_in      = acc_ff;
      a1_in       = a1_ff;
      hcnt_in     = hcnt_ff;
      valid_in    = valid_ff;
      ram_wr_en   = 1'b0;
      ram_wr_data = '{lcg: lcg_ff, walk: walk_ff, smooth: smooth_ff};
      div_req     = '{start: 1'b0, num: '0, den: DIV_DEN_W'(1)};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               chan_in   = req_data.channel;
               reseed_in = req_data.reseed;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            lcg_in    = entry.lcg;
            walk_in   = entry.walk;
            smooth_in = entry.smooth;
            sample_in = '0;
            if (!chan_ok) begin
               state_in = ST_DONE;
            end else if (reseed_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = '{lcg: (seed_ff != 32'd0) ? seed_ff : SEED_DEFAULT,
                               walk: '0, smooth: '0};
               valid_in[ram_addr] = 1'b1;
               state_in = ST_DONE;
            end else if (!coef_ok_ff) begin
               state_in = ST_INC_GO;
            end else begin
               state_in = ST_LCG_MUL;
            end
         end
         ST_INC_GO: begin
            div_req  = '{start: 1'b1, num: DIV_NUM_W'({freq_ff, 14'd0}),
                         den: DIV_DEN_W'(rate1)};
            state_in = ST_INC_WAIT;
         end
         ST_INC_WAIT: begin
            if (div_sts.done) begin
               inc_in   = sat30(div_sts.quot);
               state_in = ST_JIT_GO;
            end
         end
         ST_JIT_GO: begin
            div_req  = '{start: 1'b1, num: DIV_NUM_W'({jitter_ff, 14'd0}),
                         den: DIV_DEN_W'(rate1)};
            state_in = ST_JIT_WAIT;
         end
         ST_JIT_WAIT: begin
            if (div_sts.done) begin
               jit_in   = sat30(div_sts.quot);
               state_in = ST_SHP_GO;
            end
         end
         ST_SHP_GO: begin
            div_req  = '{start: 1'b1, num: DIV_NUM_W'(shp_prod) << 30,
                         den: DIV_DEN_W'(ONE_Q30) + 38'(jit_ff) * 38'd198};
            state_in = ST_SHP_WAIT;
         end
         ST_SHP_WAIT: begin
            if (div_sts.done) begin
               ss_in    = sat30(DIV_NUM_W'(inc_ff) + div_sts.quot);
               state_in = ST_MIX_GO;
            end
         end
         ST_MIX_GO: begin
            // white noise cross-fade only at or above nine tenths of full rate
            if (mix_on) begin
               div_req  = '{start: 1'b1,
                            num: DIV_NUM_W'((35'(t_mix) << 1) + 35'(t_mix)) << 30,
                            den: SEVENTEEN_Q30 - ((38'(t_mix) << 4) - (38'(t_mix) << 1))};
               state_in = ST_MIX_WAIT;
            end else begin
               wmix_in  = '0;
               state_in = ST_K_GO;
            end
         end
         ST_MIX_WAIT: begin
            if (div_sts.done) begin
               wmix_in  = div_sts.quot[30:0];
               state_in = ST_K_GO;
            end
         end
         ST_K_GO: begin
            div_req  = '{start: 1'b1, num: DIV_NUM_W'(TWO_PI_Q32),
                         den: DIV_DEN_W'(rate1)};
            state_in = ST_K_WAIT;
         end
         ST_K_WAIT: begin
            if (div_sts.done) begin
               k_in     = (div_sts.quot > DIV_NUM_W'(W_LIMIT_Q32)) ?
                          W_LIMIT_Q32 : div_sts.quot[19:0];
               state_in = ST_W_MUL;
            end
         end
         ST_W_MUL: begin
            state_in = ST_W_RES;
         end
         ST_W_RES: begin
            // cutoff zero holds the smoother at its last value
            if (prod_ff[67:16] == '0) begin
               a1_in      = A1_ONE;
               coef_ok_in = 1'b1;
               state_in   = ST_LCG_MUL;
            end else begin
               yv_in    = yv_s[32] ? 30'd0 : yv_s[29:0];
               acc_in   = $signed(34'(EXP_COEF[7]));
               hcnt_in  = 3'd6;
               state_in = ST_EXP_MUL;
            end
         end
         ST_EXP_MUL: begin
            state_in = ST_EXP_RES;
         end
         ST_EXP_RES: begin
            // horner step of the exp polynomial
            acc_in = acc_new;
            if (hcnt_ff == 3'd0) begin
               a1_in      = (a1_raw > 35'(A1_ONE)) ? A1_ONE : a1_raw[32:0];
               coef_ok_in = 1'b1;
               state_in   = ST_LCG_MUL;
            end else begin
               hcnt_in  = hcnt_ff - 3'd1;
               state_in = ST_EXP_MUL;
            end
         end
         ST_LCG_MUL: begin
            state_in = ST_NOISE;
         end
         ST_NOISE: begin
            lcg_in   = lcg_new;
            noise_in = noise_new;
            case (method_ff)
               METHOD_WHITE: begin
                  y_in     = noise_new;
                  state_in = ST_OUT_MUL;
               end
               METHOD_LOWPASS: begin
                  x_in     = noise_new;
                  state_in = ST_LP1;
               end
               default: begin
                  state_in = ST_STEP_MUL;
               end
            endcase
         end
         ST_STEP_MUL: begin
            state_in = ST_STEP_RES;
         end
         ST_STEP_RES: begin
            walk_in  = wv[31:0];
            state_in = ST_MX1;
         end
         ST_MX1: begin
            state_in = ST_MX2;
         end
         ST_MX2: begin
            t_in     = prod_ff;
            state_in = ST_MX3;
         end
         ST_MX3: begin
            x_in     = pair_sum[61:30];
            state_in = ST_LP1;
         end
         ST_LP1: begin
            state_in = ST_LP2;
         end
         ST_LP2: begin
            t_in     = prod_ff;
            state_in = ST_LP3;
         end
         ST_LP3: begin
            y_in      = pair_sum[63:32];
            smooth_in = pair_sum[63:32];
            state_in  = ST_OUT_MUL;
         end
         ST_OUT_MUL: begin
            state_in = ST_OUT_RES;
         end
         ST_OUT_RES: begin
            // level, shift to output format, saturate
            if (v_sh > SMAX) begin
               sample_in = SMAX[SAMPLE_BITS-1:0];
            end else if (v_sh < SMIN) begin
               sample_in = SMIN[SAMPLE_BITS-1:0];
            end else begin
               sample_in = v_sh[SAMPLE_BITS-1:0];
            end
            ram_wr_en          = 1'b1;
            valid_in[ram_addr] = 1'b1;
            state_in           = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // any register write invalidates the coefficients
      if (csr_write_en) begin
         coef_ok_in = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      method_in = method_ff;
      freq_in   = freq_ff;
      jitter_in = jitter_ff;
      level_in  = level_ff;
      rate_in   = rate_ff;
      seed_in   = seed_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_METHOD: method_in = csr_wdata[1:0];
            CSR_FREQ:   freq_in   = csr_wdata[25:0];
            CSR_JITTER: jitter_in = csr_wdata[16:0];
            CSR_LEVEL:  level_in  = csr_wdata[16:0];
            CSR_RATE:   rate_in   = csr_wdata[17:0];
            CSR_SEED:   seed_in   = csr_wdata;
            default: begin
               method_in = method_ff;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.sample      = sample_ff;
         rsp_data_in.channel_out = chan_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         coef_ok_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         method_ff    <= RST_METHOD;
         freq_ff      <= RST_FREQ;
         jitter_ff    <= RST_JITTER;
         level_ff     <= RST_LEVEL;
         rate_ff      <= RST_RATE;
         seed_ff      <= RST_SEED;
      end else begin
         state_ff     <= state_in;
         coef_ok_ff   <= coef_ok_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         method_ff    <= method_in;
         freq_ff      <= freq_in;
         jitter_ff    <= jitter_in;
         level_ff     <= level_in;
         rate_ff      <= rate_in;
         seed_ff      <= seed_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      chan_ff     <= chan_in;
      reseed_ff   <= reseed_in;
      lcg_ff      <= lcg_in;
      walk_ff     <= walk_in;
      smooth_ff   <= smooth_in;
      noise_ff    <= noise_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      t_ff        <= t_in;
      sample_ff   <= sample_in;
      inc_ff      <= inc_in;
      jit_ff      <= jit_in;
      ss_ff       <= ss_in;
      wmix_ff     <= wmix_in;
      k_ff        <= k_in;
      yv_ff       <= yv_in;
      acc_ff      <= acc_in;
      a1_ff       <= a1_in;
      hcnt_ff     <= hcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_coef_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LCG_MUL) |-> coef_ok_ff)
      else $error("sample started without coefficients");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      coef_ok_ff |-> (a1_ff <= A1_ONE && wmix_ff <= ONE_Q30 && ss_ff <= ONE_Q30))
      else $error("coefficient out of range");

   a_store_write: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_DISPATCH || state_ff == ST_OUT_RES))
      else $error("channel store written outside write-back");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("finished result dropped while output busy");

endmodule

`default_nettype wire
